// ===== rtl/core/eviction_churn_tracker_unit_defines.svh =====
// Assertion helpers shared by the tracker RTL.
`ifndef EVICTION_CHURN_TRACKER_UNIT_DEFINES_SVH
`define EVICTION_CHURN_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ECT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ECT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ect_pkg.sv =====
package ect_pkg;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int SUB_W   = 3;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd2000;

    typedef enum logic [1:0] {
        MODE_EVICT   = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_PRUNE   = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   page_key;
        logic [SUB_W-1:0]   subsystem;
        logic [TIME_W-1:0]  now_ticks;
    } t_item;

    typedef struct packed {
        logic               status;
        logic               churn_hit;
        logic [CNT_W-1:0]   eviction_total;
        logic [CNT_W-1:0]   refetch_total;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  stamp;
    } t_entry;

    typedef struct packed {
        t_entry             entry;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  window;
    } t_cmp_req;

    typedef struct packed {
        logic               match;
        logic               in_window;
    } t_cmp_rsp;

endpackage

// ===== rtl/core/ect_ram.sv =====
module ect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ect_cmp.sv =====
module ect_cmp (
    input  ect_pkg::t_cmp_req i_req,
    output ect_pkg::t_cmp_rsp o_rsp
);

    import ect_pkg::*;

    logic              w_older;
    logic [TIME_W-1:0] w_age;

    assign w_older = i_req.now > i_req.entry.stamp;
    assign w_age   = i_req.now - i_req.entry.stamp;

    assign o_rsp.match     = i_req.entry.valid && (i_req.entry.key == i_req.key);
    assign o_rsp.in_window = !w_older || (w_age <= i_req.window);

endmodule

// ===== rtl/core/eviction_churn_tracker_unit.sv =====
// Eviction churn tracker. An item is taken when start is high and busy is low; every item
// gives exactly one result, shown for one cycle with o_result_valid high, and the receiver
// cannot stall it. Evict, request and prune items are paced by the single read port of the
// entry memory, which is scanned one entry a cycle through one shared key and age compare
// unit. A clear item sweeps the memory one entry a cycle. After reset the block stays busy
// while it clears the memory; the window register is written through the configuration
// channel, which is ready only while the block is idle and start is low.
`include "eviction_churn_tracker_unit_defines.svh"

module eviction_churn_tracker_unit #(
    parameter int TABLE_DEPTH     = 64,
    parameter int SUBSYSTEM_COUNT = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ect_pkg::t_item              i_item,
    output logic                        o_result_valid,
    output ect_pkg::t_result            o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ect_pkg::TIME_W-1:0]  i_cfg_wdata
);

    import ect_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = (SUBSYSTEM_COUNT > 1) ? $clog2(SUBSYSTEM_COUNT) : 1;
    localparam int EW = $bits(t_entry);
    localparam logic [AW:0]   CNT_END  = (AW+1)'(TABLE_DEPTH);
    localparam logic [AW:0]   CNT_LAST = (AW+1)'(TABLE_DEPTH - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_DEPTH - 1);

    t_state              r_state, n_state;
    logic [AW:0]         r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pidx, n_pidx;
    logic                r_init, n_init;
    t_mode               r_mode, n_mode;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SUB_W-1:0]    r_sub, n_sub;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TIME_W-1:0]   r_window;
    logic                r_found, n_found;
    logic [AW-1:0]       r_fidx, n_fidx;
    logic                r_fwithin, n_fwithin;
    logic                r_free, n_free;
    logic [AW-1:0]       r_free_idx, n_free_idx;
    logic [CNT_W-1:0]    r_evc [SUBSYSTEM_COUNT];
    logic [CNT_W-1:0]    n_evc [SUBSYSTEM_COUNT];
    logic [CNT_W-1:0]    r_rfc [SUBSYSTEM_COUNT];
    logic [CNT_W-1:0]    n_rfc [SUBSYSTEM_COUNT];
    t_result             r_res, n_res;
    logic                r_res_valid, n_res_valid;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_entry              w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [EW-1:0]       w_rdata;
    t_entry              w_rd;
    t_cmp_req            w_cmp_req;
    t_cmp_rsp            w_cmp_rsp;
    logic                w_sub_ok;
    logic [SW-1:0]       w_sidx;
    logic [CNT_W-1:0]    w_ev_cur, w_rf_cur, w_ev_bump, w_rf_bump;
    logic                w_churn;

    ect_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_entry'(w_rdata);

    assign w_cmp_req.entry  = w_rd;
    assign w_cmp_req.key    = r_key;
    assign w_cmp_req.now    = r_now;
    assign w_cmp_req.window = r_window;

    ect_cmp u_cmp (
        .i_req (w_cmp_req),
        .o_rsp (w_cmp_rsp)
    );

    assign w_sub_ok  = {1'b0, r_sub} < (SUB_W+1)'(SUBSYSTEM_COUNT);
    assign w_sidx    = r_sub[SW-1:0];
    assign w_ev_cur  = w_sub_ok ? r_evc[w_sidx] : '0;
    assign w_rf_cur  = w_sub_ok ? r_rfc[w_sidx] : '0;
    assign w_ev_bump = (&w_ev_cur) ? w_ev_cur : w_ev_cur + 1'b1;
    assign w_rf_bump = (&w_rf_cur) ? w_rf_cur : w_rf_cur + 1'b1;
    assign w_churn   = r_found && r_fwithin;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_item.mode == MODE_CLEAR) ? ST_SWEEP : ST_SCAN;
                end
            end
            ST_SWEEP: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = r_init ? ST_IDLE : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (r_pend && r_pidx == IDX_LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_init      = r_init;
        n_mode      = r_mode;
        n_key       = r_key;
        n_sub       = r_sub;
        n_now       = r_now;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_fwithin   = r_fwithin;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_evc       = r_evc;
        n_rfc       = r_rfc;
        n_res       = r_res;
        n_res_valid = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_pidx;
        w_wdata     = w_rd;
        w_wdata.valid = 1'b0;
        w_raddr     = r_cnt[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode  = i_item.mode;
                    n_key   = i_item.page_key;
                    n_sub   = i_item.subsystem;
                    n_now   = i_item.now_ticks;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_free  = 1'b0;
                    n_init  = 1'b0;
                    if (i_item.mode == MODE_CLEAR) begin
                        for (int s = 0; s < SUBSYSTEM_COUNT; s++) begin
                            n_evc[s] = '0;
                            n_rfc[s] = '0;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                w_wdata = '0;
                n_cnt   = r_cnt + 1'b1;
            end
            ST_SCAN: begin
                if (r_cnt < CNT_END) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_cnt[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_cmp_rsp.match && !r_found) begin
                        n_found   = 1'b1;
                        n_fidx    = r_pidx;
                        n_fwithin = w_cmp_rsp.in_window;
                    end
                    if (!w_rd.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pidx;
                    end
                    if (r_mode == MODE_PRUNE && w_rd.valid && !w_cmp_rsp.in_window) begin
                        w_we = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                n_res_valid          = 1'b1;
                n_res.status         = 1'b0;
                n_res.churn_hit      = 1'b0;
                n_res.eviction_total = w_ev_cur;
                n_res.refetch_total  = w_rf_cur;
                case (r_mode)
                    MODE_EVICT: begin
                        w_we          = r_found || r_free;
                        w_waddr       = r_found ? r_fidx : r_free_idx;
                        w_wdata.valid = 1'b1;
                        w_wdata.key   = r_key;
                        w_wdata.stamp = r_now;
                        n_res.status  = !(r_found || r_free);
                        if (w_sub_ok) begin
                            n_evc[w_sidx]        = w_ev_bump;
                            n_res.eviction_total = w_ev_bump;
                        end
                    end
                    MODE_REQUEST: begin
                        w_we            = r_found;
                        w_waddr         = r_fidx;
                        w_wdata         = '0;
                        n_res.churn_hit = w_churn;
                        if (w_sub_ok && w_churn) begin
                            n_rfc[w_sidx]       = w_rf_bump;
                            n_res.refetch_total = w_rf_bump;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_init      <= 1'b1;
            r_found     <= 1'b0;
            r_free      <= 1'b0;
            r_res_valid <= 1'b0;
            r_window    <= WINDOW_RESET;
            for (int s = 0; s < SUBSYSTEM_COUNT; s++) begin
                r_evc[s] <= '0;
                r_rfc[s] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_init      <= n_init;
            r_found     <= n_found;
            r_free      <= n_free;
            r_res_valid <= n_res_valid;
            r_evc       <= n_evc;
            r_rfc       <= n_rfc;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_sub      <= n_sub;
        r_now      <= n_now;
        r_fidx     <= n_fidx;
        r_fwithin  <= n_fwithin;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = !busy && !start;
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    `ECT_ASSERT_NEXT(a_finish_gives_result, i_clk, i_rst_n, r_state == ST_FINISH, o_result_valid, "finish without result strobe")
    `ECT_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `ECT_ASSERT_SAME(a_status_churn_excl, i_clk, i_rst_n, o_result_valid, !(o_result.status && o_result.churn_hit), "status and churn_hit both set")
    `ECT_ASSERT_SAME(a_idle_no_pending, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend, "read pending while idle")
    `ECT_ASSERT_SAME(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy, "result shown while busy")

endmodule

// ===== verif/eviction_churn_tracker_unit_tb.sv =====
module eviction_churn_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ect_pkg::*;

    localparam int TABLE_DEPTH     = 64;
    localparam int SUBSYSTEM_COUNT = 6;
    localparam int KEY_POOL_SIZE   = 128;
    localparam int DRAIN_LIMIT     = 400000;
    localparam int PRINT_LIMIT     = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_item                i_item = '0;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [TIME_W-1:0]    i_cfg_wdata = '0;

    t_item                pending_items[$];
    t_result              expected_results[$];
    t_result              want_result;

    logic                 entry_held[TABLE_DEPTH];
    logic [KEY_W-1:0]     entry_key[TABLE_DEPTH];
    logic [TIME_W-1:0]    entry_stamp[TABLE_DEPTH];
    logic [CNT_W-1:0]     evict_count[SUBSYSTEM_COUNT];
    logic [CNT_W-1:0]     refetch_count[SUBSYSTEM_COUNT];
    logic [TIME_W-1:0]    window_ticks;

    logic [KEY_W-1:0]     key_pool[KEY_POOL_SIZE];
    logic                 window_req = 1'b0;
    logic [TIME_W-1:0]    window_req_data = '0;
    int                   idle_pct = 0;
    int                   mismatch_count = 0;
    int                   result_count = 0;

    eviction_churn_tracker_unit #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .SUBSYSTEM_COUNT(SUBSYSTEM_COUNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_result_valid(o_result_valid),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [TIME_W-1:0] age_of(input logic [TIME_W-1:0] now,
                                                 input logic [TIME_W-1:0] stamp);
        return (now > stamp) ? now - stamp : '0;
    endfunction

    function automatic int find_held(input logic [KEY_W-1:0] key);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (entry_held[i] && entry_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_result track_item(input t_item it);
        t_result res;
        int      slot;
        logic    counted;
        res = '0;
        counted = (it.subsystem < SUBSYSTEM_COUNT);
        case (it.mode)
            MODE_EVICT: begin
                if (counted) begin
                    if (evict_count[it.subsystem] != '1) begin
                        evict_count[it.subsystem] = evict_count[it.subsystem] + 1'b1;
                    end
                end
                slot = find_held(it.page_key);
                if (slot < 0) begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                        if (!entry_held[i]) begin
                            slot = i;
                        end
                    end
                end
                if (slot >= 0) begin
                    entry_held[slot] = 1'b1;
                    entry_key[slot] = it.page_key;
                    entry_stamp[slot] = it.now_ticks;
                end else begin
                    res.status = 1'b1;
                end
            end
            MODE_REQUEST: begin
                slot = find_held(it.page_key);
                if (slot >= 0) begin
                    entry_held[slot] = 1'b0;
                    if (age_of(it.now_ticks, entry_stamp[slot]) <= window_ticks) begin
                        res.churn_hit = 1'b1;
                        if (counted) begin
                            if (refetch_count[it.subsystem] != '1) begin
                                refetch_count[it.subsystem] = refetch_count[it.subsystem] + 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_PRUNE: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (entry_held[i] && age_of(it.now_ticks, entry_stamp[i]) > window_ticks) begin
                        entry_held[i] = 1'b0;
                    end
                end
            end
            default: begin
                foreach (entry_held[i]) entry_held[i] = 1'b0;
                foreach (evict_count[i]) evict_count[i] = '0;
                foreach (refetch_count[i]) refetch_count[i] = '0;
            end
        endcase
        if (counted) begin
            res.eviction_total = evict_count[it.subsystem];
            res.refetch_total = refetch_count[it.subsystem];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch at result %0d: %s got %0h want %0h", result_count, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results = {expected_results, track_item(i_item)};
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_item <= pending_items.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                i_cfg_valid <= 1'b0;
                window_ticks = i_cfg_wdata;
                window_req = 1'b0;
            end else if (window_req && !i_cfg_valid) begin
                i_cfg_valid <= 1'b1;
                i_cfg_wdata <= window_req_data;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_result[63:0], '0);
            end else begin
                want_result = expected_results.pop_front();
                if (o_result.status !== want_result.status) begin
                    report_mismatch("status", 64'(o_result.status), 64'(want_result.status));
                end
                if (o_result.churn_hit !== want_result.churn_hit) begin
                    report_mismatch("churn_hit", 64'(o_result.churn_hit),
                                    64'(want_result.churn_hit));
                end
                if (o_result.eviction_total !== want_result.eviction_total) begin
                    report_mismatch("eviction_total", 64'(o_result.eviction_total),
                                    64'(want_result.eviction_total));
                end
                if (o_result.refetch_total !== want_result.refetch_total) begin
                    report_mismatch("refetch_total", 64'(o_result.refetch_total),
                                    64'(want_result.refetch_total));
                end
            end
            result_count++;
        end
    end

    function automatic void push_item(input t_mode mode, input logic [KEY_W-1:0] key,
                                      input logic [SUB_W-1:0] sub,
                                      input logic [TIME_W-1:0] now);
        t_item it;
        it.mode = mode;
        it.page_key = key;
        it.subsystem = sub;
        it.now_ticks = now;
        pending_items = {pending_items, it};
    endfunction

    task automatic drain();
        int waited;
        waited = 0;
        while ((pending_items.size() != 0 || start || expected_results.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [TIME_W-1:0] value);
        window_req_data = value;
        window_req = 1'b1;
        while (window_req) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int idle, input int ev_pct,
                             input int rq_pct, input int pr_pct, input int pool_n,
                             input int step_max);
        t_item             it;
        int                pick;
        logic [TIME_W-1:0] tick_base;
        tick_base = $urandom;
        idle_pct = idle;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < ev_pct) begin
                it.mode = MODE_EVICT;
            end else if (pick < ev_pct + rq_pct) begin
                it.mode = MODE_REQUEST;
            end else if (pick < ev_pct + rq_pct + pr_pct) begin
                it.mode = MODE_PRUNE;
            end else begin
                it.mode = MODE_CLEAR;
            end
            if ($urandom_range(9) == 0) begin
                it.page_key = {$urandom, $urandom};
            end else begin
                it.page_key = key_pool[$urandom_range(pool_n - 1)];
            end
            it.subsystem = SUB_W'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 5) begin
                it.now_ticks = $urandom;
            end else if (pick < 10) begin
                it.now_ticks = tick_base - TIME_W'($urandom_range(step_max));
            end else begin
                if (pick >= 35) begin
                    tick_base = tick_base + TIME_W'($urandom_range(step_max));
                end
                it.now_ticks = tick_base;
            end
            pending_items = {pending_items, it};
        end
        drain();
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        foreach (entry_held[i]) entry_held[i] = 1'b0;
        foreach (evict_count[i]) evict_count[i] = '0;
        foreach (refetch_count[i]) refetch_count[i] = '0;
        window_ticks = WINDOW_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 0;
        push_item(MODE_EVICT,   '0,          3'd0, '0);
        push_item(MODE_EVICT,   '1,          3'd5, '1);
        push_item(MODE_EVICT,   '0,          3'd0, 32'd100);
        push_item(MODE_REQUEST, '0,          3'd0, 32'd2100);
        push_item(MODE_REQUEST, '0,          3'd0, 32'd2100);
        push_item(MODE_REQUEST, '1,          3'd7, '0);
        push_item(MODE_EVICT,   key_pool[0], 3'd6, 32'd1000);
        push_item(MODE_REQUEST, key_pool[0], 3'd1, 32'd3001);
        push_item(MODE_EVICT,   key_pool[1], 3'd2, 32'd5000);
        push_item(MODE_EVICT,   key_pool[2], 3'd3, 32'd7000);
        push_item(MODE_PRUNE,   key_pool[1], 3'd2, 32'd7001);
        push_item(MODE_REQUEST, key_pool[1], 3'd2, 32'd7001);
        push_item(MODE_REQUEST, key_pool[2], 3'd3, 32'd7001);
        push_item(MODE_EVICT,   key_pool[3], 3'd4, 32'd10);
        push_item(MODE_EVICT,   key_pool[4], 3'd1, 32'd20);
        push_item(MODE_EVICT,   key_pool[5], 3'd7, 32'd30);
        push_item(MODE_CLEAR,   key_pool[3], 3'd4, 32'd40);
        push_item(MODE_REQUEST, key_pool[3], 3'd4, 32'd40);
        push_item(MODE_PRUNE,   key_pool[4], 3'd7, '1);
        push_item(MODE_CLEAR,   key_pool[4], 3'd6, '0);
        drain();

        write_window('0);
        run_phase(300, 0, 45, 40, 10, 40, 3);
        write_window('1);
        run_phase(300, 79, 65, 30, 5, 100, 1000);
        write_window(TIME_W'($urandom_range(5000, 100)));
        run_phase(400, 27, 45, 35, 15, 80, 800);
        write_window(WINDOW_RESET);
        run_phase(500, 0, 55, 30, 12, 70, 600);

        repeat (TABLE_DEPTH + 8) @(negedge i_clk);
        if (expected_results.size() != 0 || pending_items.size() != 0) begin
            report_mismatch("items still outstanding", 64'(expected_results.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ect_pkg.sv
rtl/core/ect_ram.sv
rtl/core/ect_cmp.sv
rtl/core/eviction_churn_tracker_unit.sv
verif/eviction_churn_tracker_unit_tb.sv
